// ===== hw/rtl/isqr_pkg.sv =====
// shared types, constants and corner tables for the isometric sprite quad rotator
package isqr_pkg;

    localparam int ANGLE_BITS      = 12;
    localparam int COORD_FRAC_BITS = 4;

    // field widths
    localparam int LOC_W   = 17;
    localparam int LOCZ_W  = 12;
    localparam int TEX_W   = 10;
    localparam int VERT_W  = 24;
    localparam int SLOT_W  = 3;

    // isometric projection
    localparam int ISO_HALF_TILE = 22;
    localparam int ISO_TILE      = 44;
    localparam int Z_SCALE       = 4;

    // sine in q1.14
    localparam int SIN_FRAC = 14;
    localparam int SIN_W    = SIN_FRAC + 2;
    localparam int ONE_Q14  = 1 << SIN_FRAC;
    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // quarter-wave polynomial, z in q16 of a quarter turn
    localparam int              Z_W    = 17;
    localparam logic [16:0]     POLY_A = 17'd102944;
    localparam logic [15:0]     POLY_B = 16'd42334;
    localparam logic [12:0]     POLY_C = 13'd5223;

    // output saturation
    localparam int SAT_MAX = (1 << (VERT_W - 1)) - 1;
    localparam int SAT_MIN = -(1 << (VERT_W - 1));

    // vertex slots
    localparam logic [SLOT_W-1:0] VTX_FIRST = 3'd0;
    localparam logic [SLOT_W-1:0] VTX_LAST  = 3'd5;

    // corners by sign of (dx, dy): n = minus, p = plus
    localparam logic [1:0] C_NN = 2'd0;
    localparam logic [1:0] C_PN = 2'd1;
    localparam logic [1:0] C_NP = 2'd2;
    localparam logic [1:0] C_PP = 2'd3;

    // two triangles, shared corners repeated
    localparam logic [1:0] SLOT_CORNER [6] = '{C_NN, C_PN, C_NP, C_PN, C_NP, C_PP};

    typedef struct packed {
        logic [LOC_W-1:0]         loc_x;
        logic [LOC_W-1:0]         loc_y;
        logic signed [LOCZ_W-1:0] loc_z;
        logic [TEX_W-1:0]         tex_width;
        logic [TEX_W-1:0]         tex_height;
        logic                     fixed_angle;
        logic [ANGLE_BITS-1:0]    angle;
    } t_sprite;

    typedef struct packed {
        logic [SLOT_W-1:0]        vertex_index;
        logic signed [VERT_W-1:0] vertex_x;
        logic signed [VERT_W-1:0] vertex_y;
        logic                     last_vertex;
    } t_vertex;

endpackage

// ===== hw/rtl/isqr_stream_if.sv =====
// valid/ready stream channel carrying one payload per transaction
interface isqr_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/isometric_sprite_quad_rotate_top.sv =====
// isometric sprite quad rotator: projection, rotation and six-vertex output
//
// i_sprite takes one sprite per transaction (tile position, texture size,
// angle, fixed-angle flag). o_vertex gives six transactions per sprite, slots
// 0 to 5 in order, two triangles with the shared corners repeated; last_vertex
// marks slot 5. Coordinates are signed sixteenth pixels, saturated to 24 bits.
// A sprite passes the nine pipeline stages, then the vertex register, before
// vertex 0 is offered. The single vertex port takes the next sprite only as
// the last vertex of the one before is taken; the nine-stage pipeline itself
// takes a new sprite every cycle while it is not stalled, and holds up to
// nine sprites plus the one being sent out.
// When o_vertex is stalled the vertex register holds; once the last stage
// holds a sprite that cannot move into it, every stage freezes and
// i_sprite.ready drops, so nothing is lost or sent twice.
// Reset (synchronous, active low) empties the pipeline and the vertex
// register; the data registers themselves are not reset.
module isometric_sprite_quad_rotate_top
    import isqr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    isqr_stream_if.sink          i_sprite,
    isqr_stream_if.source        o_vertex
);

    localparam int NSTG    = 9;
    localparam int F       = COORD_FRAC_BITS;
    localparam int PV_W    = 25;
    localparam int PX_W    = 21;
    localparam int VZ_W    = 26;
    localparam int CS_W    = 24;
    localparam int PR_W    = 27;
    localparam int UV_W    = 28;
    localparam int T_W     = 40;
    localparam int RND_SH  = 15 - F;

    // truncating divide bias for negative values
    localparam logic signed [PV_W-1:0] PV_BIAS = PV_W'((1 << F) - 1);
    localparam logic signed [VZ_W-1:0] VZ_BIAS = VZ_W'((1 << F) - 1);

    function automatic logic signed [VERT_W-1:0] round_sat(input logic signed [T_W-1:0] t);
        logic signed [T_W-1:0] sum;
        logic signed [T_W-1:0] sh;
        logic signed [VERT_W-1:0] res;
        sum = t + (T_W'(1) <<< (RND_SH - 1));
        sh  = sum >>> RND_SH;
        if (sh > T_W'(SAT_MAX)) begin
            res = VERT_W'(SAT_MAX);
        end else if (sh < T_W'(SAT_MIN)) begin
            res = VERT_W'(SAT_MIN);
        end else begin
            res = VERT_W'(sh);
        end
        return res;
    endfunction

    // handshake and stage control
    logic                w_en;
    logic                w_in_fire;
    logic                w_out_fire;
    logic                w_load;
    logic [NSTG-1:0]     r_vld;

    // stage a inputs
    logic [ANGLE_BITS-1:0]    w_ang_sin;
    logic [ANGLE_BITS-1:0]    w_ang_cos;
    logic signed [LOC_W:0]    w_diff;
    logic [LOC_W:0]           w_sum;
    logic signed [PV_W-1:0]   w_vx;
    logic signed [PV_W-1:0]   w_vy0;
    logic signed [PV_W-1:0]   w_vx_t;
    logic signed [PV_W-1:0]   w_vy0_t;
    logic signed [VZ_W-1:0]   w_vz;
    logic signed [VZ_W-1:0]   w_vz_t;

    logic signed [SIN_W-1:0]  w_sin;
    logic signed [SIN_W-1:0]  w_cos;

    // stage a
    logic signed [PV_W-1:0]   r_vxa, r_vy0a;
    logic signed [LOCZ_W-1:0] r_lza, r_lzb;
    logic [TEX_W-1:0]         r_wa, r_wb, r_wc, r_wd, r_we, r_wf;
    logic [TEX_W-1:0]         r_ha, r_hb, r_hc, r_hd, r_he, r_hf;
    // stage b
    logic signed [PX_W-1:0]   r_pxb, r_py0b;
    // stage c
    logic signed [PX_W-1:0]   r_pxc;
    logic signed [VZ_W-1:0]   r_vzc;
    // stage d
    logic signed [PX_W-1:0]   r_pxd, r_pyd;
    // stage e, f
    logic signed [CS_W-1:0]   r_cxe, r_cye, r_cxf, r_cyf;
    // stage g
    logic signed [PR_W-1:0]   r_wcg, r_hsg, r_wsg, r_hcg;
    logic signed [T_W-1:0]    r_cxg, r_cyg;
    // stage h
    logic signed [UV_W-1:0]   r_u1h, r_u2h, r_v1h, r_v2h;
    logic signed [T_W-1:0]    r_cxh, r_cyh;
    // stage i, one entry per corner
    logic signed [T_W-1:0]    r_txi [4];
    logic signed [T_W-1:0]    r_tyi [4];

    // vertex register
    logic                     r_busy;
    logic [SLOT_W-1:0]        r_slot;
    logic signed [VERT_W-1:0] r_vx [4];
    logic signed [VERT_W-1:0] r_vy [4];

    assign w_out_fire = o_vertex.valid && o_vertex.ready;
    // whole pipeline moves unless the last stage is full and cannot hand over
    assign w_en       = !r_vld[NSTG-1] || !r_busy || (r_slot == VTX_LAST && o_vertex.ready);
    assign w_in_fire  = i_sprite.valid && w_en;
    assign w_load     = w_en && r_vld[NSTG-1];
    assign i_sprite.ready = w_en;

    always_comb begin
        w_ang_sin = i_sprite.data.fixed_angle ? '0 : i_sprite.data.angle;
        w_ang_cos = w_ang_sin + ANGLE_QUARTER;

        w_diff = $signed({1'b0, i_sprite.data.loc_x}) - $signed({1'b0, i_sprite.data.loc_y});
        w_sum  = (LOC_W + 1)'(i_sprite.data.loc_x) + (LOC_W + 1)'(i_sprite.data.loc_y);

        w_vx  = PV_W'(w_diff) * PV_W'(ISO_HALF_TILE)
              - (PV_W'(i_sprite.data.tex_width[TEX_W-1:1]) << F)
              + (PV_W'(ISO_HALF_TILE) << F);
        w_vy0 = PV_W'(w_sum) * PV_W'(ISO_HALF_TILE)
              - (PV_W'(i_sprite.data.tex_height) << F)
              + (PV_W'(ISO_TILE) << F);

        w_vx_t  = r_vxa + (r_vxa[PV_W-1] ? PV_BIAS : '0);
        w_vy0_t = r_vy0a + (r_vy0a[PV_W-1] ? PV_BIAS : '0);

        w_vz   = (VZ_W'(r_py0b) << F) - VZ_W'(r_lzb) * VZ_W'(Z_SCALE);
        w_vz_t = r_vzc + (r_vzc[VZ_W-1] ? VZ_BIAS : '0);
    end

    isqr_sine u_sin (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_ang_sin),
        .o_sine  (w_sin)
    );

    isqr_sine u_cos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_ang_cos),
        .o_sine  (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_in_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // a: raw projection sums
            r_vxa  <= w_vx;
            r_vy0a <= w_vy0;
            r_lza  <= i_sprite.data.loc_z;
            r_wa   <= i_sprite.data.tex_width;
            r_ha   <= i_sprite.data.tex_height;
            // b: truncate to whole pixels
            r_pxb  <= PX_W'(w_vx_t >>> F);
            r_py0b <= PX_W'(w_vy0_t >>> F);
            r_lzb  <= r_lza;
            r_wb   <= r_wa;
            r_hb   <= r_ha;
            // c: height offset
            r_vzc  <= w_vz;
            r_pxc  <= r_pxb;
            r_wc   <= r_wb;
            r_hc   <= r_hb;
            // d
            r_pyd  <= PX_W'(w_vz_t >>> F);
            r_pxd  <= r_pxc;
            r_wd   <= r_wc;
            r_hd   <= r_hc;
            // e: centre in half pixels
            r_cxe  <= (CS_W'(r_pxd) <<< 1) + CS_W'(r_wd);
            r_cye  <= (CS_W'(r_pyd) <<< 1) + CS_W'(r_hd);
            r_we   <= r_wd;
            r_he   <= r_hd;
            // f: wait for the sine pipes
            r_cxf  <= r_cxe;
            r_cyf  <= r_cye;
            r_wf   <= r_we;
            r_hf   <= r_he;
            // g: half-extent products
            r_wcg  <= PR_W'($signed({1'b0, r_wf})) * PR_W'(w_cos);
            r_hsg  <= PR_W'($signed({1'b0, r_hf})) * PR_W'(w_sin);
            r_wsg  <= PR_W'($signed({1'b0, r_wf})) * PR_W'(w_sin);
            r_hcg  <= PR_W'($signed({1'b0, r_hf})) * PR_W'(w_cos);
            r_cxg  <= T_W'(r_cxf) <<< SIN_FRAC;
            r_cyg  <= T_W'(r_cyf) <<< SIN_FRAC;
            // h
            r_u1h  <= UV_W'(r_wcg) - UV_W'(r_hsg);
            r_u2h  <= UV_W'(r_wcg) + UV_W'(r_hsg);
            r_v1h  <= UV_W'(r_wsg) + UV_W'(r_hcg);
            r_v2h  <= UV_W'(r_wsg) - UV_W'(r_hcg);
            r_cxh  <= r_cxg;
            r_cyh  <= r_cyg;
            // i: four corners
            r_txi[C_NN] <= r_cxh - T_W'(r_u1h);
            r_txi[C_PN] <= r_cxh + T_W'(r_u2h);
            r_txi[C_NP] <= r_cxh - T_W'(r_u2h);
            r_txi[C_PP] <= r_cxh + T_W'(r_u1h);
            r_tyi[C_NN] <= r_cyh - T_W'(r_v1h);
            r_tyi[C_PN] <= r_cyh + T_W'(r_v2h);
            r_tyi[C_NP] <= r_cyh - T_W'(r_v2h);
            r_tyi[C_PP] <= r_cyh + T_W'(r_v1h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < 4; i++) begin
                r_vx[i] <= round_sat(r_txi[i]);
                r_vy[i] <= round_sat(r_tyi[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= VTX_FIRST;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_slot <= VTX_FIRST;
        end else if (w_out_fire) begin
            if (r_slot == VTX_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    assign o_vertex.valid             = r_busy;
    assign o_vertex.data.vertex_index = r_slot;
    assign o_vertex.data.vertex_x     = r_vx[SLOT_CORNER[r_slot]];
    assign o_vertex.data.vertex_y     = r_vy[SLOT_CORNER[r_slot]];
    assign o_vertex.data.last_vertex  = (r_slot == VTX_LAST);

endmodule

// ===== hw/rtl/isqr_sine.sv =====
// pipelined quarter-wave polynomial sine, q1.14 result, six register stages
module isqr_sine
    import isqr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [ANGLE_BITS-1:0]   i_angle,
    output logic signed [SIN_W-1:0] o_sine
);

    localparam int QR_BITS = ANGLE_BITS - 2;
    localparam int Z_SHIFT = 16 - QR_BITS;
    localparam logic [QR_BITS:0] QUARTER = (QR_BITS + 1)'(1) << QR_BITS;

    logic [1:0]         w_quad;
    logic [QR_BITS:0]   w_rem;
    logic [Z_W-1:0]     w_z;
    logic [2*Z_W-1:0]   w_zz;
    logic [29:0]        w_m1;
    logic [32:0]        w_m2;
    logic [34:0]        w_rnd;
    logic [16:0]        w_mag;
    logic [16:0]        w_cap;

    logic [Z_W-1:0]     r_za, r_zb, r_zc, r_zd;
    logic               r_nega, r_negb, r_negc, r_negd, r_nege;
    logic [Z_W-1:0]     r_z2b, r_z2c;
    logic [15:0]        r_t1c;
    logic [16:0]        r_td;
    logic [2*Z_W-1:0]   r_pe;
    logic signed [SIN_W-1:0] r_sine;

    always_comb begin
        w_quad = i_angle[ANGLE_BITS-1 -: 2];
        w_rem  = {1'b0, i_angle[QR_BITS-1:0]};
        // odd quadrants run the quarter wave backwards
        if (w_quad[0]) begin
            w_rem = QUARTER - w_rem;
        end
        w_z   = Z_W'(w_rem) << Z_SHIFT;
        w_zz  = (2*Z_W)'(r_za) * (2*Z_W)'(r_za);
        w_m1  = 30'(r_z2b) * 30'(POLY_C);
        w_m2  = 33'(r_z2c) * 33'(r_t1c);
        w_rnd = 35'(r_pe) + (35'(1) << 17);
        w_mag = w_rnd[34:18];
        w_cap = (w_mag > 17'(ONE_Q14)) ? 17'(ONE_Q14) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_za   <= w_z;
            r_nega <= w_quad[1];

            r_z2b  <= w_zz[16 +: Z_W];
            r_zb   <= r_za;
            r_negb <= r_nega;

            r_t1c  <= POLY_B - 16'(w_m1[29:16]);
            r_z2c  <= r_z2b;
            r_zc   <= r_zb;
            r_negc <= r_negb;

            r_td   <= POLY_A - 17'(w_m2[32:16]);
            r_zd   <= r_zc;
            r_negd <= r_negc;

            r_pe   <= (2*Z_W)'(r_zd) * (2*Z_W)'(r_td);
            r_nege <= r_negd;

            r_sine <= r_nege ? -SIN_W'(w_cap) : SIN_W'(w_cap);
        end
    end

    assign o_sine = r_sine;

endmodule

// ===== hw/rtl/isqr_checker.sv =====
// port-level checks on the vertex stream, bound to the top level
module isqr_checker
    import isqr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [SLOT_W-1:0] i_out_index,
    input logic              i_out_last
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("vertex valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index))
        else $error("stalled vertex transaction changed");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == VTX_LAST)))
        else $error("last_vertex does not match slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_index <= VTX_LAST))
        else $error("vertex slot out of range");

    // a sprite's six vertices come without gaps, in slot order
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last
        |=> i_out_valid && (i_out_index == $past(i_out_index) + SLOT_W'(1)))
        else $error("vertex run broken");

endmodule

bind isometric_sprite_quad_rotate_top isqr_checker u_isqr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_vertex.valid),
    .i_out_ready (o_vertex.ready),
    .i_out_index (o_vertex.data.vertex_index),
    .i_out_last  (o_vertex.data.last_vertex)
);

// ===== tb/sv/isqr_vertex_checker.sv =====
// vertex checker for the isometric sprite quad rotator: predicts six vertices per sprite and compares
module isqr_vertex_checker
    import isqr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sprite_valid,
    input  logic    i_sprite_ready,
    input  t_sprite i_sprite_data,
    input  logic    i_vertex_valid,
    input  logic    i_vertex_ready,
    input  t_vertex i_vertex_data,
    output int      o_errors,
    output int      o_pending,
    output int      o_sprites,
    output int      o_vertices
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FRAC_ONE    = longint'(1) << COORD_FRAC_BITS;
    localparam int     ROUND_SHIFT = 15 - COORD_FRAC_BITS;
    localparam int     REM_BITS    = ANGLE_BITS - 2;
    localparam int     MAX_REPORTS = 40;

    // quarter-wave polynomial coefficients
    localparam longint SINE_K1 = 102944;
    localparam longint SINE_K3 = 42334;
    localparam longint SINE_K5 = 5223;

    t_vertex expected_vertices[$];
    int      error_count;
    int      sprite_count;
    int      vertex_count;

    // z in q16 of a quarter turn, result q1.14
    function automatic longint quarter_wave(input longint zq);
        longint z2;
        longint t;
        longint v;
        z2 = (zq * zq) >> 16;
        t  = SINE_K3 - ((z2 * SINE_K5) >> 16);
        t  = SINE_K1 - ((z2 * t) >> 16);
        v  = (zq * t + (longint'(1) << 17)) >> 18;
        if (v > ONE_Q14) v = ONE_Q14;
        return v;
    endfunction

    function automatic longint sine_of(input logic [ANGLE_BITS-1:0] a);
        logic [1:0] quad;
        longint     r;
        longint     v;
        quad = a[ANGLE_BITS-1 -: 2];
        r    = longint'(a[REM_BITS-1:0]);
        if (quad[0]) r = (longint'(1) << REM_BITS) - r;
        v = quarter_wave(r << (16 - REM_BITS));
        return quad[1] ? -v : v;
    endfunction

    function automatic longint clamp_vertex(input longint v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v;
    endfunction

    function automatic void predict_vertices(input t_sprite s);
        longint lx, ly, lz, w, h, px, py, sn, cs, cx, cy, dx, dy, tx, ty;
        logic [ANGLE_BITS-1:0] ang;
        logic [ANGLE_BITS-1:0] ang_cos;
        logic [1:0]            corner;
        t_vertex               v;
        lx = longint'(s.loc_x);
        ly = longint'(s.loc_y);
        lz = $signed(s.loc_z);
        w  = longint'(s.tex_width);
        h  = longint'(s.tex_height);
        ang     = s.fixed_angle ? '0 : s.angle;
        ang_cos = ang + ANGLE_QUARTER;

        // integer division truncates toward zero, as the projection needs
        px = ((lx - ly) * ISO_HALF_TILE - (w / 2) * FRAC_ONE + ISO_HALF_TILE * FRAC_ONE)
             / FRAC_ONE;
        py = ((lx + ly) * ISO_HALF_TILE - h * FRAC_ONE + ISO_TILE * FRAC_ONE) / FRAC_ONE;
        py = (py * FRAC_ONE - lz * Z_SCALE) / FRAC_ONE;

        sn = sine_of(ang);
        cs = sine_of(ang_cos);
        cx = (2 * px + w) * ONE_Q14;
        cy = (2 * py + h) * ONE_Q14;

        for (int i = 0; i < 6; i++) begin
            corner = SLOT_CORNER[i];
            dx = corner[0] ? w : -w;
            dy = corner[1] ? h : -h;
            tx = cx + dx * cs - dy * sn;
            ty = cy + dx * sn + dy * cs;
            v.vertex_index = SLOT_W'(i);
            v.vertex_x     = VERT_W'(clamp_vertex((tx + (longint'(1) << (ROUND_SHIFT - 1)))
                                                  >>> ROUND_SHIFT));
            v.vertex_y     = VERT_W'(clamp_vertex((ty + (longint'(1) << (ROUND_SHIFT - 1)))
                                                  >>> ROUND_SHIFT));
            v.last_vertex  = (SLOT_W'(i) == VTX_LAST);
            expected_vertices.push_back(v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n) begin
            // drain before predicting so a stray vertex never meets this cycle's sprite
            if (i_vertex_valid && i_vertex_ready) begin
                vertex_count++;
                if (expected_vertices.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected vertex, expected none, actual index %0d x %0d y %0d last %0b",
                                 $time, i_vertex_data.vertex_index, i_vertex_data.vertex_x,
                                 i_vertex_data.vertex_y, i_vertex_data.last_vertex);
                end else begin
                    want = expected_vertices.pop_front();
                    if (i_vertex_data !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t ns: vertex mismatch, expected index %0d x %0d y %0d last %0b, actual index %0d x %0d y %0d last %0b",
                                     $time, want.vertex_index, want.vertex_x, want.vertex_y,
                                     want.last_vertex, i_vertex_data.vertex_index,
                                     i_vertex_data.vertex_x, i_vertex_data.vertex_y,
                                     i_vertex_data.last_vertex);
                    end
                end
            end
            if (i_sprite_valid && i_sprite_ready) begin
                sprite_count++;
                predict_vertices(i_sprite_data);
            end
            o_pending  <= expected_vertices.size();
            o_errors   <= error_count;
            o_sprites  <= sprite_count;
            o_vertices <= vertex_count;
        end
    end

endmodule

// ===== tb/sv/isometric_sprite_quad_rotate_top_tb.sv =====
// testbench top for the isometric sprite quad rotator: stimulus, output flow control, verdict
module isometric_sprite_quad_rotate_top_tb
    import isqr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 24;
    localparam int PRESSURE_ITEMS  = 30;
    localparam int RANDOM_ITEMS    = 280;
    localparam int CALM_ITEMS      = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    isqr_stream_if #(.t_payload(t_sprite)) sprite_ch ();
    isqr_stream_if #(.t_payload(t_vertex)) vertex_ch ();

    int errors;
    int pending;
    int sprites_seen;
    int vertices_seen;
    int rotated_count;
    bit sender_idles;
    bit calm;
    bit stall_request;
    bit stall_done;

    isometric_sprite_quad_rotate_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sprite (sprite_ch),
        .o_vertex (vertex_ch)
    );

    isqr_vertex_checker vertex_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sprite_valid (sprite_ch.valid),
        .i_sprite_ready (sprite_ch.ready),
        .i_sprite_data  (sprite_ch.data),
        .i_vertex_valid (vertex_ch.valid),
        .i_vertex_ready (vertex_ch.ready),
        .i_vertex_data  (vertex_ch.data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_sprites      (sprites_seen),
        .o_vertices     (vertices_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // holds valid until the transaction completes
    task automatic offer_sprite(input t_sprite s);
        sprite_ch.valid <= 1'b1;
        sprite_ch.data  <= s;
        do @(posedge i_clk); while (sprite_ch.ready !== 1'b1);
        if (!s.fixed_angle) rotated_count++;
    endtask

    task automatic idle_gap();
        if (sender_idles && $urandom_range(0, 2) == 0) begin
            sprite_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic directed_sprite(input int x, input int y, input int z, input int w,
                                   input int h, input bit fixed, input int ang);
        t_sprite s;
        s.loc_x       = LOC_W'(x);
        s.loc_y       = LOC_W'(y);
        s.loc_z       = LOCZ_W'(z);
        s.tex_width   = TEX_W'(w);
        s.tex_height  = TEX_W'(h);
        s.fixed_angle = fixed;
        s.angle       = ANGLE_BITS'(ang);
        offer_sprite(s);
        idle_gap();
    endtask

    function automatic t_sprite random_sprite();
        t_sprite s;
        s.loc_x       = LOC_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 131071));
        s.loc_y       = LOC_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 131071));
        s.loc_z       = LOCZ_W'($urandom_range(0, 4095));
        s.tex_width   = TEX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 1023));
        s.tex_height  = TEX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 1023));
        s.fixed_angle = ($urandom_range(0, 3) == 0);
        s.angle       = ANGLE_BITS'($urandom_range(0, 4095));
        return s;
    endfunction

    // output side flow control, with one long hold-off on request
    initial begin
        vertex_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (stall_request && !stall_done) begin
                vertex_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                stall_done = 1'b1;
            end else if (calm || $urandom_range(0, 3) == 0) begin
                vertex_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                vertex_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                vertex_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    initial begin
        sprite_ch.valid <= 1'b0;
        sprite_ch.data  <= '0;
        i_rst_n         <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idles = 1'b1;
        // corners of the field ranges and the axis angles
        directed_sprite(0, 0, 0, 0, 0, 1'b0, 0);
        directed_sprite(131071, 0, 0, 1023, 1023, 1'b1, 0);
        directed_sprite(0, 131071, 0, 1023, 1023, 1'b0, 0);
        directed_sprite(131071, 131071, 2047, 1023, 1023, 1'b0, 2048);
        directed_sprite(131071, 131071, -2048, 1022, 1022, 1'b0, 4095);
        directed_sprite(3, 100, -1, 17, 9, 1'b0, 1024);
        directed_sprite(0, 0, 2047, 0, 1023, 1'b0, 3072);
        directed_sprite(0, 0, 1, 1023, 0, 1'b0, 512);
        directed_sprite(5, 7, -5, 1, 1, 1'b0, 1);
        directed_sprite(5, 7, 5, 1, 1, 1'b0, 1023);
        directed_sprite(65536, 65535, 1365, 682, 341, 1'b1, 1234);
        directed_sprite(43690, 87381, -1366, 341, 682, 1'b1, 4095);
        directed_sprite(1, 2, 3, 33, 65, 1'b0, 1025);
        directed_sprite(1, 2, 3, 33, 65, 1'b0, 2047);
        directed_sprite(1, 2, 3, 33, 65, 1'b0, 3071);
        directed_sprite(1, 2, 3, 33, 65, 1'b0, 3073);
        directed_sprite(15, 31, 15, 512, 511, 1'b0, 256);
        directed_sprite(131070, 1, -2047, 2, 3, 1'b0, 2730);
        directed_sprite(12, 4000, 100, 1000, 2, 1'b0, 1365);
        directed_sprite(100000, 99999, -100, 999, 1001, 1'b0, 3584);

        // back to back while the output side holds off, so the pipeline fills
        sender_idles  = 1'b0;
        stall_request = 1'b1;
        for (int n = 0; n < PRESSURE_ITEMS; n++) offer_sprite(random_sprite());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (calm)
                sender_idles = 1'b0;
            else if (n % 20 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);
            offer_sprite(random_sprite());
            idle_gap();
        end
        sprite_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d sprites (%0d rotated) and %0d vertices under random flow control,",
                 sprites_seen, rotated_count, vertices_seen);
        $display("including a %0d-cycle output hold-off with the sprite input backed up",
                 HOLD_OFF_CYCLES);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
